// File: src/rgbnv_pkg.sv
// ----------------------------------------------------------------------------
// rgbnv_pkg
// Shared types and constants for the BGRA to NV12 converter core.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbnv_pkg;

    localparam int CFG_DATA_W   = 14;
    localparam int CFG_INDEX_W  = 2;
    localparam int WIDTH_W      = 13;
    localparam int HEIGHT_W     = 13;
    localparam int STRIDE_W     = 14;
    localparam int COLOR_W      = 8;
    localparam int SUM_W        = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_STRIDE = 2'd2;

    localparam logic [WIDTH_W-1:0]  RST_FRAME_WIDTH  = 13'd640;
    localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [STRIDE_W-1:0] RST_OUT_STRIDE   = 14'd640;

    // BT.601 integer coefficients (chroma terms as magnitudes)
    localparam logic [SUM_W-1:0] K_Y_R   = 17'd66;
    localparam logic [SUM_W-1:0] K_Y_G   = 17'd129;
    localparam logic [SUM_W-1:0] K_Y_B   = 17'd25;
    localparam logic [SUM_W-1:0] K_U_R   = 17'd38;
    localparam logic [SUM_W-1:0] K_U_G   = 17'd74;
    localparam logic [SUM_W-1:0] K_U_B   = 17'd112;
    localparam logic [SUM_W-1:0] K_V_R   = 17'd112;
    localparam logic [SUM_W-1:0] K_V_G   = 17'd94;
    localparam logic [SUM_W-1:0] K_V_B   = 17'd18;
    localparam logic [SUM_W-1:0] K_ROUND = 17'd128;
    // rounding plus 128 offset pre-shifted into bits [15:8]
    localparam logic [SUM_W-1:0] K_UV_BIAS = 17'd32896;
    localparam logic [COLOR_W-1:0] Y_OFFSET = 8'd16;

    typedef struct packed {
        logic [WIDTH_W-1:0]  frame_width;
        logic [HEIGHT_W-1:0] frame_height;
        logic [STRIDE_W-1:0] out_stride;
    } cfg_t;

    typedef struct packed {
        logic produce;
        logic chroma;
        logic eof;
    } pos_flags_t;

endpackage

`default_nettype wire

// File: src/rgbnv_ctl.sv
// ----------------------------------------------------------------------------
// rgbnv_ctl
// Configuration registers and raster position counters.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbnv_ctl
    import rgbnv_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096,
    parameter int CNT_W = 12,
    parameter int DIM_W = 13
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   pixel_accept,
    output logic [CNT_W-1:0]            row,
    output logic [CNT_W-1:0]            col,
    output pos_flags_t                  flags,
    output logic [DIM_W-1:0]            chroma_base,
    output logic [STRIDE_W-1:0]         stride
);

    localparam logic [CFG_DATA_W-1:0] MAX_CMP = CFG_DATA_W'(MAX_DIMENSION);

    cfg_t             cfg_reg, cfg_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0] w_clamp, h_clamp, w_even, h_even;
    logic [DIM_W-1:0] col_inc, row_inc;
    logic             empty;
    logic             cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign w_clamp = (CFG_DATA_W'(cfg_reg.frame_width) > MAX_CMP) ?
                     DIM_W'(MAX_DIMENSION) : DIM_W'(cfg_reg.frame_width);
    assign h_clamp = (CFG_DATA_W'(cfg_reg.frame_height) > MAX_CMP) ?
                     DIM_W'(MAX_DIMENSION) : DIM_W'(cfg_reg.frame_height);
    assign w_even  = {w_clamp[DIM_W-1:1], 1'b0};
    assign h_even  = {h_clamp[DIM_W-1:1], 1'b0};
    assign empty   = (w_even == '0) || (h_even == '0);

    assign col_inc = DIM_W'(col_reg) + DIM_W'(1);
    assign row_inc = DIM_W'(row_reg) + DIM_W'(1);

    assign row           = row_reg;
    assign col           = col_reg;
    assign flags.produce = !empty && (DIM_W'(row_reg) < h_even);
    assign flags.chroma  = row_reg[0] && !col_reg[0];
    assign flags.eof     = (row_inc == h_even) && (col_inc == w_even);
    assign chroma_base   = h_clamp;
    assign stride        = cfg_reg.out_stride;

    always_comb begin
        cfg_next = cfg_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                CFG_IDX_WIDTH: begin
                    cfg_next.frame_width = cfg_data[WIDTH_W-1:0];
                    col_next = '0;
                    row_next = '0;
                end
                CFG_IDX_HEIGHT: begin
                    cfg_next.frame_height = cfg_data[HEIGHT_W-1:0];
                    col_next = '0;
                    row_next = '0;
                end
                CFG_IDX_STRIDE: begin
                    cfg_next.out_stride = cfg_data;
                    col_next = '0;
                    row_next = '0;
                end
                default: begin
                end
            endcase
        end else if (pixel_accept) begin
            if (empty) begin
                col_next = '0;
                row_next = '0;
            end else if (col_inc >= w_even) begin
                col_next = '0;
                row_next = (row_inc >= h_clamp) ? '0 : row_inc[CNT_W-1:0];
            end else begin
                col_next = col_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width  <= RST_FRAME_WIDTH;
            cfg_reg.frame_height <= RST_FRAME_HEIGHT;
            cfg_reg.out_stride   <= RST_OUT_STRIDE;
            col_reg              <= '0;
            row_reg              <= '0;
        end else begin
            cfg_reg <= cfg_next;
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg == '0) || (DIM_W'(col_reg) < w_even))
        else $error("column counter outside row");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_reg == '0) || (DIM_W'(row_reg) < h_clamp))
        else $error("row counter outside frame");

    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_write && (cfg_index == CFG_IDX_WIDTH || cfg_index == CFG_IDX_HEIGHT ||
                       cfg_index == CFG_IDX_STRIDE))
        |=> (col_reg == '0 && row_reg == '0))
        else $error("register write did not restart frame");

endmodule

`default_nettype wire

// File: src/rgbnv_csc.sv
// ----------------------------------------------------------------------------
// rgbnv_csc
// Input register, BT.601 color conversion and plane address arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbnv_csc
    import rgbnv_pkg::*;
#(
    parameter int CNT_W = 12,
    parameter int DIM_W = 13,
    parameter int ADDRESS_BITS = 26
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    pix_valid,
    output logic                         pix_ready,
    input  wire logic [COLOR_W-1:0]      blue,
    input  wire logic [COLOR_W-1:0]      green,
    input  wire logic [COLOR_W-1:0]      red,
    input  wire logic [CNT_W-1:0]        row,
    input  wire logic [CNT_W-1:0]        col,
    input  wire pos_flags_t              flags,
    input  wire logic [DIM_W-1:0]        chroma_base,
    input  wire logic [STRIDE_W-1:0]     stride,
    output logic                         res_valid,
    input  wire logic                    res_ready,
    output logic [ADDRESS_BITS-1:0]      luma_addr,
    output logic [COLOR_W-1:0]           luma_val,
    output logic [ADDRESS_BITS-1:0]      chroma_addr,
    output logic [2*COLOR_W-1:0]         chroma_val,
    output logic                         has_chroma,
    output logic                         eof
);

    localparam int LPROD_W = CNT_W + STRIDE_W;
    localparam int CBASE_W = DIM_W + 1;
    localparam int CPROD_W = CBASE_W + STRIDE_W;

    logic                 valid_reg, valid_next;
    logic [COLOR_W-1:0]   blue_reg, green_reg, red_reg;
    logic [CNT_W-1:0]     row_reg, col_reg;
    logic                 chroma_reg, eof_reg;
    logic                 load;
    logic [SUM_W-1:0]     r_ext, g_ext, b_ext;
    logic [SUM_W-1:0]     y_sum, u_sum, v_sum;
    logic [CBASE_W-1:0]   cbase;
    logic [LPROD_W-1:0]   luma_prod;
    logic [CPROD_W-1:0]   chroma_prod;

    assign pix_ready  = !valid_reg || res_ready;
    assign load       = pix_valid && pix_ready;
    assign valid_next = load ? flags.produce : (valid_reg && !res_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            blue_reg   <= blue;
            green_reg  <= green;
            red_reg    <= red;
            row_reg    <= row;
            col_reg    <= col;
            chroma_reg <= flags.chroma;
            eof_reg    <= flags.eof;
        end
    end

    assign r_ext = SUM_W'(red_reg);
    assign g_ext = SUM_W'(green_reg);
    assign b_ext = SUM_W'(blue_reg);

    assign y_sum = K_Y_R * r_ext + K_Y_G * g_ext + K_Y_B * b_ext + K_ROUND;
    assign u_sum = K_U_B * b_ext + K_UV_BIAS - K_U_R * r_ext - K_U_G * g_ext;
    assign v_sum = K_V_R * r_ext + K_UV_BIAS - K_V_G * g_ext - K_V_B * b_ext;

    assign cbase       = CBASE_W'(chroma_base) + CBASE_W'(row_reg[CNT_W-1:1]);
    assign luma_prod   = LPROD_W'(row_reg) * LPROD_W'(stride);
    assign chroma_prod = CPROD_W'(cbase) * CPROD_W'(stride);

    assign res_valid   = valid_reg;
    assign luma_addr   = ADDRESS_BITS'(luma_prod + LPROD_W'(col_reg));
    assign luma_val    = y_sum[15:8] + Y_OFFSET;
    assign chroma_addr = ADDRESS_BITS'(chroma_prod + CPROD_W'(col_reg));
    assign chroma_val  = {v_sum[15:8], u_sum[15:8]};
    assign has_chroma  = chroma_reg;
    assign eof         = eof_reg;

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !res_ready)
        |=> (valid_reg && $stable(row_reg) && $stable(col_reg) && $stable(red_reg)))
        else $error("stalled pixel lost or changed");

    a_eof_no_chroma: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && eof_reg) |-> !chroma_reg)
        else $error("end of frame on chroma pixel");

endmodule

`default_nettype wire

// File: src/rgbnv_out.sv
// ----------------------------------------------------------------------------
// rgbnv_out
// Result register; sends the luma result and then the optional chroma pair.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbnv_out
    import rgbnv_pkg::*;
#(
    parameter int ADDRESS_BITS = 26,
    parameter int TDATA_W = 48
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    res_valid,
    output logic                         res_ready,
    input  wire logic [ADDRESS_BITS-1:0] luma_addr,
    input  wire logic [COLOR_W-1:0]      luma_val,
    input  wire logic [ADDRESS_BITS-1:0] chroma_addr,
    input  wire logic [2*COLOR_W-1:0]    chroma_val,
    input  wire logic                    has_chroma,
    input  wire logic                    eof,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [TDATA_W-1:0]           m_tdata,
    output logic                         m_tlast,
    output logic [1:0]                   m_tuser
);

    logic                    luma_v_reg, luma_v_next;
    logic                    chroma_v_reg, chroma_v_next;
    logic [ADDRESS_BITS-1:0] luma_addr_reg, chroma_addr_reg;
    logic [COLOR_W-1:0]      luma_val_reg;
    logic [2*COLOR_W-1:0]    chroma_val_reg;
    logic                    eof_reg;
    logic                    xfer, single, load;

    assign xfer      = m_tvalid && m_tready;
    assign single    = luma_v_reg ^ chroma_v_reg;
    assign res_ready = !(luma_v_reg || chroma_v_reg) || (m_tready && single);
    assign load      = res_valid && res_ready;

    always_comb begin
        luma_v_next   = luma_v_reg;
        chroma_v_next = chroma_v_reg;
        if (load) begin
            luma_v_next   = 1'b1;
            chroma_v_next = has_chroma;
        end else if (xfer) begin
            if (luma_v_reg) begin
                luma_v_next = 1'b0;
            end else begin
                chroma_v_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            luma_v_reg   <= 1'b0;
            chroma_v_reg <= 1'b0;
        end else begin
            luma_v_reg   <= luma_v_next;
            chroma_v_reg <= chroma_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            luma_addr_reg   <= luma_addr;
            luma_val_reg    <= luma_val;
            chroma_addr_reg <= chroma_addr;
            chroma_val_reg  <= chroma_val;
            eof_reg         <= eof;
        end
    end

    assign m_tvalid   = luma_v_reg || chroma_v_reg;
    assign m_tdata    = luma_v_reg ?
                        TDATA_W'({8'd0, luma_val_reg, luma_addr_reg}) :
                        TDATA_W'({chroma_val_reg, chroma_addr_reg});
    assign m_tlast    = luma_v_reg && eof_reg;
    assign m_tuser[0] = !luma_v_reg;
    assign m_tuser[1] = !(luma_v_reg && chroma_v_reg);

    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (xfer && luma_v_reg && chroma_v_reg) |=> (m_tvalid && m_tuser[0]))
        else $error("chroma pair not sent after its luma");

    a_chroma_tags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[1] && !m_tlast))
        else $error("chroma transfer with wrong tags");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (luma_v_reg && chroma_v_reg && !m_tready) |=> (luma_v_reg && chroma_v_reg))
        else $error("pending pair overwritten");

endmodule

`default_nettype wire

// File: src/rgb32_to_nv12_converter_core.sv
// ----------------------------------------------------------------------------
// rgb32_to_nv12_converter_core
// BGRA pixel stream in raster order to NV12 byte writes (BT.601 luma and
// subsampled U,V pairs) with frame buffer addresses.
// ----------------------------------------------------------------------------
//  channel   direction  content
//  s_*       in         one BGRA pixel per transfer (alpha not carried)
//  m_*       out        one luma byte or one U,V pair write per transfer
//  cfg_*     in         register write: 0 width, 1 height, 2 out stride
//
//  One pixel per cycle on luma-only pixels while the output is not stalled; on odd
//  rows each even-column pixel gives two results, luma then U,V pair, at the output.
//  A pixel passes the input register, then the result register.
//  aresetn is synchronous; it clears counters and restores default registers.
//  s_tready stays high while the result register can take the next pixel.
//  A write to register 0, 1 or 2 restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb32_to_nv12_converter_core
    import rgbnv_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096,
    parameter int ADDRESS_BITS = 26
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // [7:0] blue, [15:8] green, [23:16] red
    input  wire logic [23:0]             s_tdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // [ADDRESS_BITS-1:0] write_address, next 16 bits write_value, zero pad
    output logic [((ADDRESS_BITS+16+7)/8)*8-1:0] m_tdata,
    output logic                         m_tlast,
    // [0] is_chroma, [1] last_of_item
    output logic [1:0]                   m_tuser,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int CNT_W   = $clog2(MAX_DIMENSION);
    localparam int DIM_W   = $clog2(MAX_DIMENSION + 1);
    localparam int TDATA_W = ((ADDRESS_BITS + 16 + 7) / 8) * 8;

    logic [CNT_W-1:0]        row, col;
    pos_flags_t              flags;
    logic [DIM_W-1:0]        chroma_base;
    logic [STRIDE_W-1:0]     stride;
    logic                    res_valid, res_ready;
    logic [ADDRESS_BITS-1:0] luma_addr, chroma_addr;
    logic [COLOR_W-1:0]      luma_val;
    logic [2*COLOR_W-1:0]    chroma_val;
    logic                    has_chroma, eof;

    rgbnv_ctl #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .CNT_W         (CNT_W),
        .DIM_W         (DIM_W)
    ) u_ctl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_accept (s_tvalid && s_tready),
        .row          (row),
        .col          (col),
        .flags        (flags),
        .chroma_base  (chroma_base),
        .stride       (stride)
    );

    rgbnv_csc #(
        .CNT_W        (CNT_W),
        .DIM_W        (DIM_W),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_csc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pix_valid   (s_tvalid),
        .pix_ready   (s_tready),
        .blue        (s_tdata[7:0]),
        .green       (s_tdata[15:8]),
        .red         (s_tdata[23:16]),
        .row         (row),
        .col         (col),
        .flags       (flags),
        .chroma_base (chroma_base),
        .stride      (stride),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .luma_addr   (luma_addr),
        .luma_val    (luma_val),
        .chroma_addr (chroma_addr),
        .chroma_val  (chroma_val),
        .has_chroma  (has_chroma),
        .eof         (eof)
    );

    rgbnv_out #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .TDATA_W      (TDATA_W)
    ) u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .luma_addr   (luma_addr),
        .luma_val    (luma_val),
        .chroma_addr (chroma_addr),
        .chroma_val  (chroma_val),
        .has_chroma  (has_chroma),
        .eof         (eof),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire

// File: dv/rgb32_to_nv12_converter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb32_to_nv12_converter_core_tb
// Self-checking bench for the BGRA to NV12 converter core. A directed table
// covers color extremes, row and frame wrap, odd sizes, empty frames,
// saturated sizes, address wrap and register restarts. Random frames follow
// under several sender and receiver idle patterns. Every write transfer is
// compared against an in-bench model of the converter.
// ----------------------------------------------------------------------------

module rgb32_to_nv12_converter_core_tb;
    import rgbnv_pkg::*;

    localparam int MAX_DIM       = 4096;
    localparam int ADDR_W        = 26;
    localparam int M_DATA_W      = ((ADDR_W + 16 + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PIXELS = 1550;
    localparam int WIDE_PIXELS   = 120;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [15:0]       value;
        logic              chroma;
        logic              last_of_pixel;
        logic              eof;
    } nv12_write_t;

    typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_data;
        logic [23:0]            bgr;
        bit                     has_luma;
        logic [7:0]             luma;
    } stim_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [23:0]            s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   m_tlast;
    logic [1:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // converter model state
    logic [WIDTH_W-1:0]  mdl_width  = 13'd640;
    logic [HEIGHT_W-1:0] mdl_height = 13'd480;
    logic [STRIDE_W-1:0] mdl_stride = 14'd640;
    int unsigned         pos_col    = 0;
    int unsigned         pos_row    = 0;

    nv12_write_t expected_writes[$];
    stim_row_t   directed_rows[$];
    int          mismatches     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    rgb32_to_nv12_converter_core #(
        .MAX_DIMENSION(MAX_DIM),
        .ADDRESS_BITS(ADDR_W)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void apply_register(logic [CFG_INDEX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        if (idx > CFG_IDX_STRIDE) return;
        case (idx)
            CFG_IDX_WIDTH:  mdl_width  = data[WIDTH_W-1:0];
            CFG_IDX_HEIGHT: mdl_height = data[HEIGHT_W-1:0];
            CFG_IDX_STRIDE: mdl_stride = data[STRIDE_W-1:0];
            default: ;
        endcase
        pos_col = 0;
        pos_row = 0;
    endfunction

    // Expected writes for one pixel; has_luma forces a typed-in luma byte.
    function automatic void convert_pixel(logic [23:0] bgr, bit has_luma,
                                          logic [7:0] luma);
        int          b, g, r, y, u, v;
        int unsigned w, h, he;
        bit          pair;
        nv12_write_t wr;
        b = bgr[7:0];
        g = bgr[15:8];
        r = bgr[23:16];
        w = (mdl_width > MAX_DIM) ? MAX_DIM : mdl_width;
        w = w - (w % 2);
        h = (mdl_height > MAX_DIM) ? MAX_DIM : mdl_height;
        he = h - (h % 2);
        if (w == 0 || he == 0) begin
            pos_col = 0;
            pos_row = 0;
            return;
        end
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= h) pos_row = 0;
        if (pos_row < he) begin
            y = ((66 * r + 129 * g + 25 * b + 128) >> 8) + 16;
            pair = (pos_row % 2 == 1) && (pos_col % 2 == 0);
            wr.addr = longint'(pos_row) * longint'(mdl_stride) + pos_col;
            wr.value = {8'h00, y[7:0]};
            if (has_luma) wr.value[7:0] = luma;
            wr.chroma = 1'b0;
            wr.last_of_pixel = !pair;
            wr.eof = (pos_row == he - 1) && (pos_col == w - 1);
            expected_writes.push_back(wr);
            if (pair) begin
                u = (-38 * r - 74 * g + 112 * b + 128 + 32768) >> 8;
                v = (112 * r - 94 * g - 18 * b + 128 + 32768) >> 8;
                wr.addr = (longint'(h) + (pos_row >> 1)) * longint'(mdl_stride) + pos_col;
                wr.value = {v[7:0], u[7:0]};
                wr.chroma = 1'b1;
                wr.last_of_pixel = 1'b1;
                wr.eof = 1'b0;
                expected_writes.push_back(wr);
            end
        end
        pos_col++;
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= h) pos_row = 0;
        end
    endfunction

    function automatic stim_row_t row_pixel(logic [23:0] bgr, bit has_luma = 1'b0,
                                            logic [7:0] luma = 8'd0);
        stim_row_t row;
        row.kind = ROW_PIXEL;
        row.reg_index = '0;
        row.reg_data = '0;
        row.bgr = bgr;
        row.has_luma = has_luma;
        row.luma = luma;
        return row;
    endfunction

    function automatic stim_row_t row_reg(logic [CFG_INDEX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row = row_pixel(24'h0);
        row.kind = ROW_REG;
        row.reg_index = idx;
        row.reg_data = data;
        return row;
    endfunction

    task automatic send_pixel(logic [23:0] bgr, bit has_luma = 1'b0,
                              logic [7:0] luma = 8'd0);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 24'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bgr;
        do @(posedge aclk); while (!s_tready);
        convert_pixel(bgr, has_luma, luma);
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (expected_writes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx,
                                  logic [CFG_DATA_W-1:0] data);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_register(idx, data);
    endtask

    task automatic setup_random_frame();
        int w, h, s, pick;
        pick = $urandom_range(0, 99);
        w = (pick < 6) ? $urandom_range(0, 1) : $urandom_range(2, 12);
        pick = $urandom_range(0, 99);
        if (pick < 6)       h = $urandom_range(0, 1);
        else if (pick < 14) h = $urandom_range(MAX_DIM + 1, 8191);
        else                h = $urandom_range(2, 9);
        pick = $urandom_range(0, 99);
        if (pick < 5)       s = 16383;
        else if (pick < 8)  s = $urandom_range(0, 1);
        else if (pick < 20) s = $urandom_range(2, 16383);
        else                s = $urandom_range(2, 24);
        if ($urandom_range(0, 3) == 0)
            write_register(CFG_IDX_UNUSED, 14'($urandom));
        write_register(CFG_IDX_WIDTH, {1'($urandom_range(0, 1)), 13'(w)});
        write_register(CFG_IDX_HEIGHT, {1'($urandom_range(0, 1)), 13'(h)});
        write_register(CFG_IDX_STRIDE, 14'(s));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else          m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : result_check
        nv12_write_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected transfer data=%h user=%b last=%b",
                             $time, m_tdata, m_tuser, m_tlast);
            end else begin
                exp_w = expected_writes.pop_front();
                if (m_tdata !== {{(M_DATA_W - ADDR_W - 16){1'b0}}, exp_w.value, exp_w.addr}
                        || m_tuser !== {exp_w.last_of_pixel, exp_w.chroma}
                        || m_tlast !== exp_w.eof) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: mismatch addr exp %h act %h, value exp %h act %h, ",
                                  "chroma exp %b act %b, last exp %b act %b, ",
                                  "eof exp %b act %b, pad %h"},
                                 $time, exp_w.addr, m_tdata[ADDR_W-1:0],
                                 exp_w.value, m_tdata[ADDR_W+15:ADDR_W],
                                 exp_w.chroma, m_tuser[0], exp_w.last_of_pixel,
                                 m_tuser[1], exp_w.eof, m_tlast,
                                 m_tdata[M_DATA_W-1:ADDR_W+16]);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("rgb32_to_nv12_converter_core test failed");
        $finish;
    end

    initial begin
        int sent;
        int phase;
        int n;
        logic [23:0] px;

        // defaults after reset
        directed_rows.push_back(row_pixel(24'h000000, 1'b1, 8'd16));
        directed_rows.push_back(row_pixel(24'hFFFFFF, 1'b1, 8'd235));
        // unknown register: position must carry on
        directed_rows.push_back(row_reg(CFG_IDX_UNUSED, 14'd5));
        directed_rows.push_back(row_pixel(24'h0000FF));
        // 2x3 frame: odd last row is swallowed
        directed_rows.push_back(row_reg(CFG_IDX_WIDTH, 14'd2));
        directed_rows.push_back(row_reg(CFG_IDX_HEIGHT, 14'd3));
        directed_rows.push_back(row_reg(CFG_IDX_STRIDE, 14'd4));
        directed_rows.push_back(row_pixel(24'hFF0000));
        directed_rows.push_back(row_pixel(24'h00FF00));
        directed_rows.push_back(row_pixel(24'h0000FF));
        directed_rows.push_back(row_pixel(24'h808080));
        directed_rows.push_back(row_pixel(24'h123456));
        directed_rows.push_back(row_pixel(24'h654321));
        directed_rows.push_back(row_pixel(24'hFFFFFF));
        // odd width 5 acts as 4
        directed_rows.push_back(row_reg(CFG_IDX_WIDTH, 14'd5));
        directed_rows.push_back(row_reg(CFG_IDX_HEIGHT, 14'd2));
        directed_rows.push_back(row_pixel(24'hFF0000));
        directed_rows.push_back(row_pixel(24'hFFFF00));
        directed_rows.push_back(row_pixel(24'h00FFFF));
        directed_rows.push_back(row_pixel(24'h000000));
        directed_rows.push_back(row_pixel(24'hFFFF00));
        directed_rows.push_back(row_pixel(24'h00FF00));
        // empty frame
        directed_rows.push_back(row_reg(CFG_IDX_WIDTH, 14'd1));
        directed_rows.push_back(row_pixel(24'hA5A5A5));
        directed_rows.push_back(row_pixel(24'h5A5A5A));
        // saturated height and chroma address wrap; width has bit 13 set
        directed_rows.push_back(row_reg(CFG_IDX_WIDTH, 14'h2002));
        directed_rows.push_back(row_reg(CFG_IDX_HEIGHT, 14'd8191));
        directed_rows.push_back(row_reg(CFG_IDX_STRIDE, 14'd16383));
        directed_rows.push_back(row_pixel(24'h102030));
        directed_rows.push_back(row_pixel(24'h405060));
        directed_rows.push_back(row_pixel(24'hFF00FF));
        directed_rows.push_back(row_pixel(24'h708090));
        directed_rows.push_back(row_pixel(24'hA0B0C0));
        directed_rows.push_back(row_pixel(24'hD0E0F0));
        directed_rows.push_back(row_pixel(24'h00FFFF));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG)
                write_register(directed_rows[i].reg_index, directed_rows[i].reg_data);
            else
                send_pixel(directed_rows[i].bgr, directed_rows[i].has_luma,
                           directed_rows[i].luma);
        end

        // width above the limit with a large stride
        write_register(CFG_IDX_WIDTH, 14'($urandom_range(MAX_DIM + 1, 8191)));
        write_register(CFG_IDX_HEIGHT, 14'd2);
        write_register(CFG_IDX_STRIDE, 14'($urandom_range(MAX_DIM, 16383)));
        for (int i = 0; i < WIDE_PIXELS; i++)
            send_pixel(24'($urandom));

        sent = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            setup_random_frame();
            n = $urandom_range(40, 120);
            for (int i = 0; i < n; i++) begin
                px = 24'($urandom);
                if ($urandom_range(0, 9) == 0)
                    px = {{8{1'($urandom_range(0, 1))}}, {8{1'($urandom_range(0, 1))}},
                          {8{1'($urandom_range(0, 1))}}};
                send_pixel(px);
            end
            sent += n;
            phase++;
        end

        wait_quiet();
        if (mismatches == 0 && expected_writes.size() == 0)
            $display("rgb32_to_nv12_converter_core test passed");
        else
            $display("rgb32_to_nv12_converter_core test failed");
        $finish;
    end

endmodule

// File: filelist.f
src/rgbnv_pkg.sv
src/rgbnv_ctl.sv
src/rgbnv_csc.sv
src/rgbnv_out.sv
src/rgb32_to_nv12_converter_core.sv
dv/rgb32_to_nv12_converter_core_tb.sv
